>>> hw/rtl/ksuid_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ksuid_pkg: shared constants, types and helpers
// Widths, the epoch offset, the divide-by-62 constants, the control FSM type
// and the base-62 alphabet lookup.
// ----------------------------------------------------------------------------
package ksuid_pkg;

  localparam int unsigned SECS_W   = 34;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned RAND_W   = 64;
  localparam int unsigned NUM_W    = TIME_W + 2 * RAND_W;   // 160
  localparam int unsigned CHUNK_W  = 8;
  localparam int unsigned CHUNKS   = NUM_W / CHUNK_W;        // 20
  localparam int unsigned CHUNK_CW = $clog2(CHUNKS);
  localparam int unsigned DIGIT_W  = 6;
  localparam int unsigned DIGITS   = 27;
  localparam int unsigned DIGIT_CW = $clog2(DIGITS);
  localparam int unsigned CHAR_W   = 7;
  localparam int unsigned X_W      = DIGIT_W + CHUNK_W;      // partial dividend
  localparam int unsigned RECIP_W  = 11;
  localparam int unsigned PROD_W   = X_W + RECIP_W;
  localparam int unsigned RECIP_SH = 16;

  localparam logic [SECS_W-1:0]   KS_EPOCH = SECS_W'(64'd1400000000);
  localparam logic [CHAR_W-1:0]   KS_BASE  = CHAR_W'(62);
  // floor(2^16 / 62): estimate is exact or one low for any 14-bit dividend
  localparam logic [RECIP_W-1:0]  KS_RECIP = RECIP_W'(1057);
  localparam logic [CHUNK_CW-1:0] CHUNK_LAST = CHUNK_CW'(CHUNKS - 1);
  localparam logic [DIGIT_CW-1:0] DIGIT_LAST = DIGIT_CW'(DIGITS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } ks_state_t;

  typedef struct packed {
    logic               push;
    logic               pop;
    logic [DIGIT_W-1:0] digit;
  } ks_stack_ctl_t;

  typedef struct packed {
    logic               done;
    logic [DIGIT_W-1:0] digit;
  } ks_div_stat_t;

  // 0-9, A-Z, a-z; codes past 61 map to '0'
  function automatic logic [CHAR_W-1:0] ks_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dz;
    dz = CHAR_W'(d);
    if (d < DIGIT_W'(10)) begin
      ks_ascii = dz + CHAR_W'(48);
    end else if (d < DIGIT_W'(36)) begin
      ks_ascii = dz + CHAR_W'(55);
    end else if (d < DIGIT_W'(62)) begin
      ks_ascii = dz + CHAR_W'(61);
    end else begin
      ks_ascii = CHAR_W'(48);
    end
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/ksuid_div62.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ksuid_div62: byte-serial divide-by-62 of the 160-bit number
// One byte per cycle while run is high, from the top of a rotating shift
// register; quotient bytes enter at the bottom. A full pass yields one digit.
// ----------------------------------------------------------------------------
module ksuid_div62 import ksuid_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire logic [NUM_W-1:0] load_num,
  input  wire logic             run,
  output ks_div_stat_t          stat
);

  logic [NUM_W-1:0]    num_r, num_nxt;
  logic [DIGIT_W-1:0]  rem_r, rem_nxt;
  logic [CHUNK_CW-1:0] cnt_r, cnt_nxt;

  logic [X_W-1:0]     x;
  logic [PROD_W-1:0]  prod;
  logic [CHUNK_W-1:0] q_est, q;
  logic [X_W-1:0]     r_est;
  logic [DIGIT_W-1:0] r;
  logic               pass_end;

  always_comb begin
    x     = {rem_r, num_r[NUM_W-1 -: CHUNK_W]};
    prod  = PROD_W'(x) * PROD_W'(KS_RECIP);
    q_est = prod[RECIP_SH +: CHUNK_W];
    r_est = x - X_W'(q_est) * X_W'(KS_BASE);
    // single correction step
    if (r_est >= X_W'(KS_BASE)) begin
      q = q_est + CHUNK_W'(1);
      r = DIGIT_W'(r_est - X_W'(KS_BASE));
    end else begin
      q = q_est;
      r = DIGIT_W'(r_est);
    end
  end

  assign pass_end = run && (cnt_r == CHUNK_LAST);

  always_comb begin
    num_nxt = num_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (load) begin
      num_nxt = load_num;
      rem_nxt = '0;
      cnt_nxt = '0;
    end else if (run) begin
      num_nxt = {num_r[NUM_W-CHUNK_W-1:0], q};
      rem_nxt = pass_end ? '0 : r;
      cnt_nxt = pass_end ? '0 : cnt_r + CHUNK_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      cnt_r <= '0;
    end else begin
      rem_r <= rem_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
  end

  assign stat.done  = pass_end;
  assign stat.digit = r;

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CHUNK_LAST) else $error("chunk counter out of range");
  a_pass_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    pass_end && !load |=> cnt_r == '0 && rem_r == '0)
    else $error("pass did not restart");
  a_load_clr: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> cnt_r == '0 && rem_r == '0) else $error("load did not clear pass");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/ksuid_digit_stack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ksuid_digit_stack: LIFO of base-62 digits in a shift line
// Digits arrive least significant first and leave most significant first.
// ----------------------------------------------------------------------------
module ksuid_digit_stack import ksuid_pkg::*; (
  input  wire logic          clk,
  input  wire ks_stack_ctl_t ctl,
  output logic [DIGIT_W-1:0] top
);

  logic [DIGIT_W-1:0] stk_r   [DIGITS];
  logic [DIGIT_W-1:0] stk_nxt [DIGITS];

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      stk_nxt[i] = stk_r[i];
    end
    if (ctl.push) begin
      stk_nxt[0] = ctl.digit;
      for (int i = 1; i < DIGITS; i++) begin
        stk_nxt[i] = stk_r[i-1];
      end
    end else if (ctl.pop) begin
      for (int i = 0; i < DIGITS - 1; i++) begin
        stk_nxt[i] = stk_r[i+1];
      end
      stk_nxt[DIGITS-1] = '0;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DIGITS; i++) begin
      stk_r[i] <= stk_nxt[i];
    end
  end

  assign top = stk_r[0];

endmodule
`default_nettype wire

>>> hw/rtl/ksuid_base62_formatter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ksuid_base62_formatter: KSUID string encoder
// Turns a Unix time and 128 random bits into the 27-character base-62 KSUID.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one transfer carries unix_seconds,
//   random_high and random_low. The epoch offset is subtracted modulo 2^32
//   and the 160-bit number {time, random_high, random_low} is formed.
//   Output channel (out_valid/out_ready): 27 transfers per item, one ASCII
//   character each, most significant digit first, zero padded;
//   out_last_char marks the 27th.
//   Flow: the divider consumes one byte per cycle and produces each digit
//   in a full pass over all 20 bytes of the number; all 27 digits are
//   produced before the first character is offered. Characters then
//   transfer one per cycle while out_ready is high, and in_ready returns
//   the cycle after the last character.
//   Stalls: out_ready low simply holds the current character; nothing is
//   lost. Divider progress does not depend on the output side.
//   Reset (rst_n low, synchronous): returns to idle, drops any item in
//   flight, in_ready high on the first cycle after reset.
// ----------------------------------------------------------------------------
module ksuid_base62_formatter import ksuid_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [SECS_W-1:0]  in_unix_seconds,
  input  wire logic [RAND_W-1:0]  in_random_high,
  input  wire logic [RAND_W-1:0]  in_random_low,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [CHAR_W-1:0]       out_character,
  output logic                    out_last_char
);

  ks_state_t           state_r, state_nxt;
  logic [DIGIT_CW-1:0] dcnt_r, dcnt_nxt;   // digits produced / emitted

  logic                in_xfer, out_xfer;
  logic                div_load, div_run;
  logic [TIME_W-1:0]   secs;
  logic [NUM_W-1:0]    load_num;
  ks_div_stat_t        div_stat;
  ks_stack_ctl_t       stk_ctl;
  logic [DIGIT_W-1:0]  stk_top;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // epoch shift, wraps to 32 bits
  assign secs     = TIME_W'(in_unix_seconds - KS_EPOCH);
  assign load_num = {secs, in_random_high, in_random_low};

  // next state
  always_comb begin
    state_nxt = state_r;
    dcnt_nxt  = dcnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_DIVIDE;
          dcnt_nxt  = '0;
        end
      end
      ST_DIVIDE: begin
        if (div_stat.done) begin
          if (dcnt_r == DIGIT_LAST) begin
            state_nxt = ST_EMIT;
            dcnt_nxt  = '0;
          end else begin
            dcnt_nxt = dcnt_r + DIGIT_CW'(1);
          end
        end
      end
      ST_EMIT: begin
        if (out_xfer) begin
          if (dcnt_r == DIGIT_LAST) begin
            state_nxt = ST_IDLE;
            dcnt_nxt  = '0;
          end else begin
            dcnt_nxt = dcnt_r + DIGIT_CW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        dcnt_nxt  = '0;
      end
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    div_load      = 1'b0;
    div_run       = 1'b0;
    stk_ctl.push  = 1'b0;
    stk_ctl.pop   = 1'b0;
    stk_ctl.digit = div_stat.digit;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        div_load = in_valid;
      end
      ST_DIVIDE: begin
        div_run      = 1'b1;
        stk_ctl.push = div_stat.done;
      end
      ST_EMIT: begin
        out_valid   = 1'b1;
        stk_ctl.pop = out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      dcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      dcnt_r  <= dcnt_nxt;
    end
  end

  ksuid_div62 u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (div_load),
    .load_num (load_num),
    .run      (div_run),
    .stat     (div_stat)
  );

  ksuid_digit_stack u_stack (
    .clk (clk),
    .ctl (stk_ctl),
    .top (stk_top)
  );

  assign out_character = ks_ascii(stk_top);
  assign out_last_char = out_valid && (dcnt_r == DIGIT_LAST);

`ifndef ASSERT_OFF
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input and output open together");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready && !out_valid) else $error("not busy after transfer");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && out_last_char |=> in_ready) else $error("no idle after last char");
  a_emit_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> dcnt_r == '0) else $error("emit started mid-string");
`endif

endmodule
`default_nettype wire
